// File: rtl/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; simulation bodies are dropped when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HCD_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("deframer assertion failed");

`define HCD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("deframer forbidden condition seen");

`else

`define HCD_ASSERT(lbl, clk_s, rstn_s, prop)

`define HCD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

// File: rtl/hcd_pkg.sv
// shared types and constants for the header/tail checksum deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

	localparam int PACKET_BYTES_DEF = 14;
	localparam int DATA_BYTES_DEF   = 9;
	localparam int DATA_FIRST_POS   = 3;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND_RST = 8'h55;
	localparam logic [7:0] TAIL_RST       = 8'hFF;

	typedef enum logic [1:0] {
		REG_HDR_FIRST  = 2'd0,
		REG_HDR_SECOND = 2'd1,
		REG_TAIL       = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] tail_marker;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_FILL  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_ERR   = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// File: rtl/header_tail_checksum_deframer.sv
// check: the byte that fills the window is checked in the cycle after its transfer;
// the first result is registered from the emit or error state once the output is free
// throughput: one byte per cycle while filling; while resyncing on a full window each byte
// is taken, then checked; a good packet holds the input through the check and a full
// window rotation, a checksum error through check and ST_ERR; output stalls lengthen both
// reset: control, window cells and checksum clear; registers return to aa/55/ff
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module header_tail_checksum_deframer #(
	parameter int PACKET_BYTES = hcd_pkg::PACKET_BYTES_DEF,
	parameter int DATA_BYTES   = hcd_pkg::DATA_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [hcd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [hcd_pkg::DATA_W-1:0] pwdata,
	output logic      [hcd_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [7:0]                out_byte,
	output logic      [3:0]                byte_pos,
	output logic                           last,
	output logic                           status
);

	import hcd_pkg::*;

	localparam int POS_W  = $clog2(PACKET_BYTES);
	localparam int SUM_HI = (DATA_FIRST_POS + DATA_BYTES - 1 < PACKET_BYTES - 1)
		? DATA_FIRST_POS + DATA_BYTES - 1 : PACKET_BYTES - 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

	cfg_t   cfg;
	state_t state_q;

	logic [7:0]       cell_byte [PACKET_BYTES];
	logic [7:0]       shift_in;
	logic             shift_en;
	logic [7:0]       enter_byte;
	logic [7:0]       sum_q;
	logic [7:0]       sum_d;
	logic [POS_W-1:0] fill_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W+3:0] pos_ext;
	logic             in_xfer;
	logic             out_free;
	logic             frame_ok;
	logic             sum_ok;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [3:0] byte_pos_q;
	logic       last_q;
	logic       status_q;

	hcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// window chain: oldest byte in cell 0, new bytes enter at the far end
	genvar k;
	generate
		for (k = 0; k < PACKET_BYTES; k++) begin : g_cell
			logic [7:0] cell_d;
			if (k == PACKET_BYTES - 1) begin : g_end
				assign cell_d = shift_in;
			end else begin : g_mid
				assign cell_d = cell_byte[k+1];
			end
			hcd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (cell_d),
				.q        (cell_byte[k])
			);
		end
		if (SUM_HI + 1 == PACKET_BYTES) begin : g_enter_end
			assign enter_byte = shift_in;
		end else begin : g_enter_mid
			assign enter_byte = cell_byte[SUM_HI+1];
		end
	endgenerate

	assign in_stall = (state_q != ST_FILL);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign shift_en = in_xfer || ((state_q == ST_EMIT) && out_free);
	// during emission the chain rotates so the window comes back intact
	assign shift_in = (state_q == ST_EMIT) ? cell_byte[0] : rx_byte;

	// running modulo-256 sum over the data positions of the window
	assign sum_d = sum_q + enter_byte - cell_byte[DATA_FIRST_POS];

	assign frame_ok = (cell_byte[0] == cfg.header_first)
		&& (cell_byte[1] == cfg.header_second)
		&& (cell_byte[PACKET_BYTES-1] == cfg.tail_marker);
	assign sum_ok = (sum_q == cell_byte[PACKET_BYTES-2]);

	assign pos_ext = {4'b0000, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'h00;
		end else if (shift_en) begin
			sum_q <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (in_xfer) begin
						if (fill_q == LAST_POS) begin
							state_q <= ST_CHECK;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_CHECK: begin
					if (!frame_ok) begin
						state_q <= ST_FILL;
					end else begin
						fill_q  <= '0;
						pos_q   <= '0;
						state_q <= sum_ok ? ST_EMIT : ST_ERR;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (pos_q == LAST_POS) begin
							pos_q   <= '0;
							state_q <= ST_FILL;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT || state_q == ST_ERR) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_EMIT) begin
				out_byte_q <= cell_byte[0];
				byte_pos_q <= pos_ext[3:0];
				last_q     <= (pos_q == LAST_POS);
				status_q   <= 1'b0;
			end else if (state_q == ST_ERR) begin
				out_byte_q <= 8'h00;
				byte_pos_q <= 4'h0;
				last_q     <= 1'b1;
				status_q   <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign byte_pos  = byte_pos_q;
	assign last      = last_q;
	assign status    = status_q;

	`HCD_ASSERT(a_err_shape, clk, arst_n,
		(out_valid_q && status_q) |-> (last_q && out_byte_q == 8'h00 && byte_pos_q == 4'h0))
	`HCD_ASSERT(a_reject_keeps_fill, clk, arst_n,
		(state_q == ST_CHECK && !frame_ok) |=> (state_q == ST_FILL && fill_q == LAST_POS))
	`HCD_ASSERT(a_accept_empties, clk, arst_n,
		(state_q == ST_CHECK && frame_ok) |=> (fill_q == '0))
	`HCD_ASSERT_NEVER(a_no_xfer_when_busy, clk, arst_n,
		shift_en && state_q != ST_FILL && state_q != ST_EMIT)

endmodule

`default_nettype wire

// File: rtl/hcd_cell.sv
// one byte cell of the deframer window chain
// no dependencies; the top level links cells into a shift line
`timescale 1ns / 1ps
`default_nettype none

module hcd_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift_en,
	input  wire logic [7:0] d,
	output logic      [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

`default_nettype wire

// File: rtl/hcd_regs.sv
// apb configuration registers: header bytes and tail marker
// depends on hcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcd_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [hcd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [hcd_pkg::DATA_W-1:0] pwdata,
	output logic      [hcd_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output hcd_pkg::cfg_t                   cfg
);

	import hcd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HDR_FIRST_RST;
			cfg_q.header_second <= HDR_SECOND_RST;
			cfg_q.tail_marker   <= TAIL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HDR_FIRST:  cfg_q.header_first  <= pwdata[7:0];
				REG_HDR_SECOND: cfg_q.header_second <= pwdata[7:0];
				REG_TAIL:       cfg_q.tail_marker   <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HDR_FIRST:  prdata[7:0] = cfg_q.header_first;
			REG_HDR_SECOND: prdata[7:0] = cfg_q.header_second;
			REG_TAIL:       prdata[7:0] = cfg_q.tail_marker;
			default:        prdata      = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire
